FILE: rtl/core/bbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants of the bilinear Bayer demosaic block.
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int PIX_W    = 8;
    localparam int FW_W     = 12;  // frame_width register
    localparam int FH_W     = 13;  // frame_height register
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // 3x3 window, entry index row*3+col, row 0 oldest line, col 0 oldest column
    typedef logic [8:0][PIX_W-1:0] t_win;

    // one output site inside the window, with its edge and color flags
    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        logic       top;
        logic       bottom;
        logic       left;
        logic       right;
        logic       odd_row;
        logic       green;
    } t_site;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

endpackage

FILE: rtl/core/bayer_bilinear_demosaic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Streaming 3x3 bilinear Bayer demosaic with two line stores in RAM.
// ----------------------------------------------------------------------------
// Path: the item that completes a pixel's window passes the line store read,
//   the window update and the output register before the result is presented.
// Throughput: one result per cycle while i_stall is low; an item in row 0 or
//   column 0 yields none, others 1, row ends and last row 2, the last one 4.
// Reset: synchronous active low; clears counters, window and handshakes and
//   sets the frame to 640x480. The line stores are not cleared.
module bayer_bilinear_demosaic #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel input
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bbd_pkg::PIX_W-1:0]       i_raw_pixel,
    // result output
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [bbd_pkg::PIX_W-1:0]       o_red,
    output logic [bbd_pkg::PIX_W-1:0]       o_green,
    output logic [bbd_pkg::PIX_W-1:0]       o_blue,
    output logic                            o_last_of_run,
    output logic                            o_frame_done,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bbd_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    // configuration
    logic [bbd_pkg::FW_W-1:0] r_frame_width;
    logic [bbd_pkg::FH_W-1:0] r_frame_height;
    logic                     cfg_wr;
    logic [XW-1:0]            wm1;
    logic [YW-1:0]            hm1;

    // position of the next item
    logic [XW-1:0] r_col, n_col;
    logic [YW-1:0] r_row, n_row;

    // item waiting for its line store data
    logic                      r_s1_valid;
    logic [bbd_pkg::PIX_W-1:0] r_s1_px;
    logic [XW-1:0]             r_s1_x;
    logic [YW-1:0]             r_s1_y;

    // window and pending result sites
    bbd_pkg::t_win r_win;
    logic [3:0]    r_pend, n_pend_rem;
    logic [XW-1:0] r_e_x;
    logic [YW-1:0] r_e_y;
    logic [1:0]    sel;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;

    bbd_pkg::t_site site;
    bbd_pkg::t_rgb  rgb;

    logic [bbd_pkg::PIX_W-1:0] older_q, newer_q;
    logic accept, adv, issue, out_free;

    // output register
    logic                      r_o_valid;
    bbd_pkg::t_rgb             r_o_rgb;
    logic                      r_o_last, r_o_done;

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bbd_pkg::FRAME_WIDTH_RST;
            r_frame_height <= bbd_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                bbd_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[bbd_pkg::FW_W-1:0];
                bbd_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[bbd_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated size minus one
    always_comb begin
        if (r_frame_width < 12'd2) begin
            wm1 = XW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            wm1 = XW'(MAX_WIDTH - 1);
        end else begin
            wm1 = XW'(r_frame_width - 12'd1);
        end
        if (r_frame_height < 13'd2) begin
            hm1 = YW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            hm1 = YW'(MAX_HEIGHT - 1);
        end else begin
            hm1 = YW'(r_frame_height - 13'd1);
        end
    end

    // ------------------------------------------------------------ handshakes
    assign out_free = !r_o_valid || !i_stall;
    assign issue    = (r_pend != 4'd0) && out_free;

    always_comb begin
        sel = 2'd0;
        if (r_pend[0]) begin
            sel = 2'd0;
        end else if (r_pend[1]) begin
            sel = 2'd1;
        end else if (r_pend[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        n_pend_rem = r_pend & ~(4'd1 << sel);
    end

    // the window may move once every site of the previous item is out
    assign adv     = r_s1_valid && ((r_pend == 4'd0) || (issue && n_pend_rem == 4'd0));
    assign o_stall = r_s1_valid && !adv;
    assign accept  = i_valid && !o_stall;

    // -------------------------------------------------------------- counters
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (r_col == wm1) begin
                n_col = '0;
                n_row = (r_row == hm1) ? '0 : r_row + YW'(1);
            end else begin
                n_col = r_col + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px <= i_raw_pixel;
            r_s1_x  <= r_col;
            r_s1_y  <= r_row;
        end
    end

    // ----------------------------------------------------------- line stores
    bbd_ram #(
        .WIDTH(bbd_pkg::PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_older (
        .i_clk     (i_clk),
        .i_wr_en   (adv),
        .i_wr_addr (r_s1_x),
        .i_wr_data (newer_q),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (older_q)
    );

    bbd_ram #(
        .WIDTH(bbd_pkg::PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_newer (
        .i_clk     (i_clk),
        .i_wr_en   (adv),
        .i_wr_addr (r_s1_x),
        .i_wr_data (r_s1_px),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (newer_q)
    );

    // ---------------------------------------------------- window and sites
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_pend <= '0;
        end else if (adv) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3+1];
                r_win[r*3 + 1] <= r_win[r*3+2];
            end
            r_win[2] <= older_q;
            r_win[5] <= newer_q;
            r_win[8] <= r_s1_px;
            // bit 0: center site, bit 1: right edge, bits 2/3: same on last row
            r_pend[0] <= (r_s1_y != '0) && (r_s1_x != '0);
            r_pend[1] <= (r_s1_y != '0) && (r_s1_x == wm1);
            r_pend[2] <= (r_s1_y != '0) && (r_s1_y == hm1) && (r_s1_x != '0);
            r_pend[3] <= (r_s1_y != '0) && (r_s1_y == hm1) && (r_s1_x == wm1);
        end else if (issue) begin
            r_pend <= n_pend_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_x <= r_s1_x;
            r_e_y <= r_s1_y;
        end
    end

    always_comb begin
        cx = sel[0] ? wm1 : r_e_x - XW'(1);
        cy = sel[1] ? r_e_y : r_e_y - YW'(1);
        site.row     = sel[1] ? 2'd2 : 2'd1;
        site.col     = sel[0] ? 2'd2 : 2'd1;
        site.top     = (cy == '0);
        site.bottom  = (cy == hm1);
        site.left    = (cx == '0);
        site.right   = (cx == wm1);
        site.odd_row = cy[0];
        site.green   = !(cx[0] ^ cy[0]);
    end

    bbd_interp u_interp (
        .i_win  (r_win),
        .i_site (site),
        .o_rgb  (rgb)
    );

    // ------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (issue) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_o_rgb  <= rgb;
            r_o_last <= (n_pend_rem == 4'd0);
            r_o_done <= site.right && site.bottom;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_red         = r_o_rgb.red;
    assign o_green       = r_o_rgb.green;
    assign o_blue        = r_o_rgb.blue;
    assign o_last_of_run = r_o_last;
    assign o_frame_done  = r_o_done;

    // ------------------------------------------------------------ assertions
    // a line store entry is never read in the cycle it is written back
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && adv) |-> (r_col != r_s1_x))
        else $error("line store read and write hit the same entry");

    // the frame's final pixel closes its item's run
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> o_last_of_run)
        else $error("frame_done without last_of_run");

    // a result that is not the last of its run still has sites pending
    a_run_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |-> (r_pend != 4'd0))
        else $error("run ended without last_of_run");

    // window must not move while sites of the previous item remain
    a_win_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 4'd0 && !issue) |=> $stable(r_win))
        else $error("window changed with results pending");

endmodule

FILE: rtl/core/bbd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/bbd_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_interp
// Bilinear interpolation of one site of the 3x3 window, edges mirrored.
// ----------------------------------------------------------------------------
module bbd_interp (
    input  bbd_pkg::t_win  i_win,
    input  bbd_pkg::t_site i_site,
    output bbd_pkg::t_rgb  o_rgb
);

    function automatic logic [bbd_pkg::PIX_W-1:0] win_at(
        input bbd_pkg::t_win win,
        input logic [1:0]    row,
        input logic [1:0]    col
    );
        logic [3:0] idx;
        idx = 4'(row) * 4'd3 + 4'(col);
        if (row == 2'd3 || col == 2'd3) begin
            return '0;
        end
        return win[idx];
    endfunction

    logic [1:0] row_up, row_dn, col_lf, col_rt;
    logic [bbd_pkg::PIX_W-1:0] ctr, hn, vn, di, gm;
    logic [bbd_pkg::PIX_W:0]   hn_sum, vn_sum, gm_sum;
    logic [bbd_pkg::PIX_W+1:0] di_sum;
    logic [bbd_pkg::PIX_W-1:0] r_ch, g_ch, b_ch;

    always_comb begin
        row_up = i_site.top    ? i_site.row + 2'd1 : i_site.row - 2'd1;
        row_dn = i_site.bottom ? i_site.row - 2'd1 : i_site.row + 2'd1;
        col_lf = i_site.left   ? i_site.col + 2'd1 : i_site.col - 2'd1;
        col_rt = i_site.right  ? i_site.col - 2'd1 : i_site.col + 2'd1;

        ctr    = win_at(i_win, i_site.row, i_site.col);
        hn_sum = {1'b0, win_at(i_win, i_site.row, col_lf)}
               + {1'b0, win_at(i_win, i_site.row, col_rt)};
        vn_sum = {1'b0, win_at(i_win, row_up, i_site.col)}
               + {1'b0, win_at(i_win, row_dn, i_site.col)};
        di_sum = {2'b00, win_at(i_win, row_up, col_lf)}
               + {2'b00, win_at(i_win, row_up, col_rt)}
               + {2'b00, win_at(i_win, row_dn, col_lf)}
               + {2'b00, win_at(i_win, row_dn, col_rt)};
        hn     = hn_sum[bbd_pkg::PIX_W:1];
        vn     = vn_sum[bbd_pkg::PIX_W:1];
        di     = di_sum[bbd_pkg::PIX_W+1:2];
        gm_sum = {1'b0, vn} + {1'b0, hn};
        gm     = gm_sum[bbd_pkg::PIX_W:1];

        if (i_site.green) begin
            g_ch = ctr;
            if (i_site.odd_row) begin
                r_ch = hn;
                b_ch = vn;
            end else begin
                r_ch = vn;
                b_ch = hn;
            end
        end else if (i_site.odd_row) begin
            r_ch = ctr;
            g_ch = gm;
            b_ch = di;
        end else begin
            b_ch = ctr;
            g_ch = gm;
            r_ch = di;
        end

        // red and blue leave swapped
        o_rgb.red   = b_ch;
        o_rgb.green = g_ch;
        o_rgb.blue  = r_ch;
    end

endmodule
